// File: hdl/pcst_pkg.sv
// ----------------------------------------------------------------------------
// pcst_pkg - shared types of the position compare sweep trigger
// Phase codes, register set, run state and result word layout.
// ----------------------------------------------------------------------------
package pcst_pkg;

	localparam int unsigned REG_W = 16;
	localparam int unsigned THR_W = 18;   // threshold, signed, covers high + step
	localparam int unsigned CMP_W = 19;   // clear limits, signed, cover 2 * step
	localparam int unsigned SCN_W = 17;
	localparam int unsigned CNT_W = 32;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
	localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
	localparam logic [1:0] REG_STEP_SIZE  = 2'd2;
	localparam logic [1:0] REG_SCAN_TOTAL = 2'd3;

	typedef enum logic [4:0] {
		PH_IDLE      = 5'b00001,
		PH_UP        = 5'b00010,
		PH_WAIT_UP   = 5'b00100,
		PH_DOWN      = 5'b01000,
		PH_WAIT_DOWN = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [REG_W-1:0] range_low;
		logic [REG_W-1:0] range_high;
		logic [REG_W-1:0] step_size;
		logic [REG_W-1:0] scan_total;
	} cfg_t;

	typedef struct packed {
		phase_t                  phase;
		logic signed [THR_W-1:0] thr;
		logic [SCN_W-1:0]        scans;
		logic [CNT_W-1:0]        fires;
		logic                    level;
	} state_t;

	typedef struct packed {
		logic             run_done;
		logic             busy;
		logic [SCN_W-1:0] scans;
		logic [CNT_W-1:0] count;
		logic             level;
		logic             pulse;
	} res_t;

endpackage

// File: hdl/pcst_step.sv
// ----------------------------------------------------------------------------
// pcst_step - next-state logic of the sweep trigger
// Works out the run state and the result word for one input word.
// ----------------------------------------------------------------------------
module pcst_step (
	input  pcst_pkg::cfg_t        cfg,
	input  pcst_pkg::state_t      cur,
	input  logic                  action,
	input  logic signed [15:0]    position,
	output pcst_pkg::state_t      nxt,
	output pcst_pkg::res_t        res
);
	import pcst_pkg::*;

	logic signed [CMP_W-1:0] pos_w;
	logic signed [CMP_W-1:0] thr_w;
	logic signed [CMP_W-1:0] lo_w;
	logic signed [CMP_W-1:0] hi_w;
	logic signed [CMP_W-1:0] step_w;
	logic signed [CMP_W-1:0] hi_clear;
	logic signed [CMP_W-1:0] lo_clear;
	logic signed [CMP_W-1:0] thr_up;
	logic signed [CMP_W-1:0] thr_dn;
	logic [SCN_W-1:0]        scan_inc;
	logic [SCN_W-1:0]        total_w;
	logic                    pulse;
	logic                    done;

	assign pos_w    = {{(CMP_W-16){position[15]}}, position};
	assign thr_w    = {cur.thr[THR_W-1], cur.thr};
	assign lo_w     = $signed({3'b000, cfg.range_low});
	assign hi_w     = $signed({3'b000, cfg.range_high});
	assign step_w   = $signed({3'b000, cfg.step_size});
	assign hi_clear = hi_w + {step_w[CMP_W-2:0], 1'b0};
	assign lo_clear = lo_w - {step_w[CMP_W-2:0], 1'b0};
	assign thr_up   = (pos_w >= thr_w) ? thr_w + step_w : thr_w;
	assign thr_dn   = (pos_w <= thr_w) ? thr_w - step_w : thr_w;
	assign scan_inc = cur.scans + 1'b1;
	assign total_w  = {1'b0, cfg.scan_total};

	always_comb begin
		nxt   = cur;
		pulse = 1'b0;
		done  = 1'b0;
		if (action) begin
			nxt.thr   = {2'b00, cfg.range_low};
			nxt.scans = '0;
			nxt.fires = '0;
			if (cfg.scan_total == '0) begin
				nxt.phase = PH_IDLE;
				done      = 1'b1;
			end else begin
				nxt.phase = PH_UP;
			end
		end else begin
			case (cur.phase)
				PH_UP: begin
					pulse   = (pos_w >= thr_w);
					nxt.thr = thr_up[THR_W-1:0];
					if (thr_up > hi_w) begin
						nxt.thr   = {2'b00, cfg.range_high};
						nxt.scans = scan_inc;
						nxt.phase = (pos_w >= hi_clear) ? PH_DOWN : PH_WAIT_UP;
					end
				end
				PH_WAIT_UP: begin
					if (pos_w >= hi_clear) begin
						nxt.phase = PH_DOWN;
					end
				end
				PH_DOWN: begin
					pulse   = (pos_w <= thr_w);
					nxt.thr = thr_dn[THR_W-1:0];
					if (thr_dn < lo_w) begin
						nxt.thr   = {2'b00, cfg.range_low};
						nxt.scans = scan_inc;
						nxt.phase = PH_WAIT_DOWN;
						// The clear limit may already be met on this same sample.
						if (pos_w <= lo_clear) begin
							if (scan_inc >= total_w) begin
								nxt.phase = PH_IDLE;
								done      = 1'b1;
							end else begin
								nxt.phase = PH_UP;
							end
						end
					end
				end
				PH_WAIT_DOWN: begin
					if (pos_w <= lo_clear) begin
						if (cur.scans >= total_w) begin
							nxt.phase = PH_IDLE;
							done      = 1'b1;
						end else begin
							nxt.phase = PH_UP;
						end
					end
				end
				default: begin
					nxt.phase = PH_IDLE;
				end
			endcase
		end
		if (pulse) begin
			nxt.level = ~cur.level;
			nxt.fires = cur.fires + 1'b1;
		end
	end

	assign res.pulse    = pulse;
	assign res.level    = nxt.level;
	assign res.count    = nxt.fires;
	assign res.scans    = nxt.scans;
	assign res.busy     = (nxt.phase != PH_IDLE);
	assign res.run_done = done;

endmodule

// File: hdl/position_compare_sweep_trigger.sv
// ----------------------------------------------------------------------------
// position_compare_sweep_trigger - encoder position compare sweep trigger
// Fires triggers at evenly spaced encoder positions, upward then downward.
// ----------------------------------------------------------------------------
// A start word (tuser high) arms a run with the threshold at range_low and
// clears the trigger and scan counts; position words then fire a trigger each
// time the position reaches the moving threshold, first upward to range_high,
// then, once the position has cleared range_high plus twice the step,
// downward to range_low, repeating until the completed scans reach
// scan_total. Every input word gives exactly one result word, in order. The
// block takes one word per clock cycle unless the result stream stalls: the
// run state (phase, threshold and counts) is updated as each word is worked
// on, so each word sees the state left by the word before it. A word waits
// in the input register and then appears in the result register; a stalled
// result holds the result register while the input register still takes one
// more word. Registers are read live and should be written only while no run
// is in progress and no word is in flight.
module position_compare_sweep_trigger (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [15:0] position (signed)
	input  logic        s_tuser,    // [0] action: 1 = start a run
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,    // [0] trigger_pulse, [1] trigger_level,
	                                // [33:2] trigger_count, [50:34] scans_done,
	                                // [51] busy_res, [55:52] zero
	output logic        m_tlast,    // run_done
	// Register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pcst_pkg::*;

	cfg_t              cfg_q;
	state_t            state_q;
	state_t            state_nxt;
	res_t              res_nxt;
	res_t              res_s2;
	logic              valid_s1;
	logic              action_s1;
	logic signed [15:0] position_s1;
	logic              valid_s2;
	logic              advance;
	logic              cfg_write;

	// ---- register port ----------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_RANGE_LOW:  cfg_q.range_low  <= pwdata[REG_W-1:0];
				REG_RANGE_HIGH: cfg_q.range_high <= pwdata[REG_W-1:0];
				REG_STEP_SIZE:  cfg_q.step_size  <= pwdata[REG_W-1:0];
				REG_SCAN_TOTAL: cfg_q.scan_total <= pwdata[REG_W-1:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_RANGE_LOW:  prdata = {16'h0000, cfg_q.range_low};
			REG_RANGE_HIGH: prdata = {16'h0000, cfg_q.range_high};
			REG_STEP_SIZE:  prdata = {16'h0000, cfg_q.step_size};
			REG_SCAN_TOTAL: prdata = {16'h0000, cfg_q.scan_total};
			default:        prdata = '0;
		endcase
	end

	// ---- flow control -----------------------------------------------------
	// The word in the input register is worked on when the result register
	// is empty or is being emptied in this cycle.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// ---- input register ---------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1   <= s_tuser;
			position_s1 <= s_tdata;
		end
	end

	// ---- run state ----------------------------------------------------------
	pcst_step u_step (
		.cfg      (cfg_q),
		.cur      (state_q),
		.action   (action_s1),
		.position (position_s1),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= PH_IDLE;
			state_q.thr   <= '0;
			state_q.scans <= '0;
			state_q.fires <= '0;
			state_q.level <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// ---- result register ----------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = res_s2.run_done;
	assign m_tdata  = {4'h0, res_s2.busy, res_s2.scans, res_s2.count,
	                   res_s2.level, res_s2.pulse};

`ifndef SYNTHESIS
	// A word that finishes the run always reports the block as idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tdata[51])
		else $error("run_done reported while still busy");

	// Each fired trigger advances the count by one and flips the level.
	a_fire_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_nxt.pulse |=>
		(state_q.fires == $past(state_q.fires) + 1'b1) &&
		(state_q.level != $past(state_q.level)))
		else $error("trigger fired without count and level update");

	// The input side stalls only while both registers hold words.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("input stalled with room in the pipeline");
`endif

endmodule

// File: test/position_compare_sweep_trigger_tb.sv
// ----------------------------------------------------------------------------
// position_compare_sweep_trigger_tb - self-checking bench for the sweep trigger
// Drives start and position words through the input stream under random
// bursts and gaps, stalls the result stream on shifting patterns, and checks
// every result word field by field against a cycle-free scan model or a pinned
// result. Register settings change only between runs, once every result is back.
// ----------------------------------------------------------------------------
module position_compare_sweep_trigger_tb;

	import pcst_pkg::*;

	// Result stream is ready on the ones of this pattern when it is in use.
	localparam logic [10:0] STALL_PAT = 11'b10110111011;

	// Directed rows: a plain word checked against the model, a word whose
	// result is written out in full, or a new set of register values.
	typedef enum logic [1:0] {
		ROW_WORD,
		ROW_PINNED,
		ROW_REGS
	} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic      act;
		logic [15:0] pos;
		cfg_t      regs;
		res_t      pinned;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;     // [15:0] position (signed)
	logic        s_tuser;     // [0] action: 1 = start a run
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;     // [0] trigger_pulse, [1] trigger_level,
	                          // [33:2] trigger_count, [50:34] scans_done,
	                          // [51] busy_res, [55:52] zero
	logic        m_tlast;     // run_done
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Our own copy of the register set and of the run state.
	cfg_t                    shadow_cfg;
	phase_t                  sweep_phase;
	logic signed [THR_W-1:0] sweep_thr;
	logic [SCN_W-1:0]        sweep_scans;
	logic [CNT_W-1:0]        sweep_fires;
	logic                    sweep_level;

	res_t      due_results[$];   // results still owed by the block, oldest first
	stim_row_t plan[$];          // directed stimulus table
	res_t      want;
	int        mismatches;
	int        burst_left;

	position_compare_sweep_trigger uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Moves the scan on by one word and returns the result it should produce.
	// The threshold and clear limits are worked in plain integers, so there is
	// no 16-bit wrap anywhere; the stored threshold always lands in 0..65535.
	function automatic res_t advance_sweep(input logic act, input logic signed [15:0] pos);
		int   p;
		int   thr;
		int   lo;
		int   hi;
		int   stp;
		res_t r;
		p   = int'(pos);
		thr = int'(sweep_thr);
		lo  = int'(shadow_cfg.range_low);
		hi  = int'(shadow_cfg.range_high);
		stp = int'(shadow_cfg.step_size);
		r   = '0;
		if (act) begin
			// A start ignores the position, keeps the level, and may finish
			// at once when no scans are asked for.
			thr         = lo;
			sweep_scans = '0;
			sweep_fires = '0;
			if (shadow_cfg.scan_total == '0) begin
				sweep_phase = PH_IDLE;
				r.run_done  = 1'b1;
			end else begin
				sweep_phase = PH_UP;
			end
		end else begin
			case (sweep_phase)
				PH_UP: begin
					if (p >= thr) begin
						sweep_level = ~sweep_level;
						sweep_fires = sweep_fires + 1'b1;
						r.pulse     = 1'b1;
						thr         = thr + stp;
					end
					if (thr > hi) begin
						thr         = hi;
						sweep_scans = sweep_scans + 1'b1;
						sweep_phase = PH_WAIT_UP;
					end
				end
				PH_DOWN: begin
					if (p <= thr) begin
						sweep_level = ~sweep_level;
						sweep_fires = sweep_fires + 1'b1;
						r.pulse     = 1'b1;
						thr         = thr - stp;
					end
					if (thr < lo) begin
						thr         = lo;
						sweep_scans = sweep_scans + 1'b1;
						sweep_phase = PH_WAIT_DOWN;
					end
				end
				default: ;
			endcase
			// The waits are looked at after the scan step, so a position that
			// already clears the limit skips the wait within the same word.
			if (sweep_phase == PH_WAIT_UP && p >= hi + 2 * stp)
				sweep_phase = PH_DOWN;
			if (sweep_phase == PH_WAIT_DOWN && p <= lo - 2 * stp) begin
				// The end check comes only here, so an odd total overshoots.
				if (sweep_scans >= shadow_cfg.scan_total) begin
					sweep_phase = PH_IDLE;
					r.run_done  = 1'b1;
				end else begin
					sweep_phase = PH_UP;
				end
			end
		end
		sweep_thr = THR_W'(thr);
		r.level   = sweep_level;
		r.count   = sweep_fires;
		r.scans   = sweep_scans;
		r.busy    = (sweep_phase != PH_IDLE);
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0h, got %0h", name, exp_v, got_v);
		end
	endfunction

	// Offers one word, waits for it to be taken, records what it must give,
	// then paces the sender: bursts of back-to-back words with idle gaps.
	// Entered and left at a falling edge.
	task automatic send_word(input logic act, input logic [15:0] pos, input logic pinned_on,
			input res_t pinned);
		res_t predicted;
		s_tuser  = act;
		s_tdata  = pos;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		predicted = advance_sweep(act, pos);
		due_results.push_back(pinned_on ? pinned : predicted);
		@(negedge clk);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 24);
		end
	endtask

	// Holds the sender off until every result is back and the pipeline is empty.
	task automatic drain();
		s_tvalid = 1'b0;
		while (due_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// One register write followed by a read of the same register.
	task automatic reg_write(input logic [1:0] idx, input logic [15:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = {16'h0000, value};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_RANGE_LOW:  shadow_cfg.range_low  = value;
			REG_RANGE_HIGH: shadow_cfg.range_high = value;
			REG_STEP_SIZE:  shadow_cfg.step_size  = value;
			default:        shadow_cfg.scan_total = value;
		endcase
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		check_field("register readback", {16'h0000, value}, prdata);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic program_regs(input cfg_t c);
		reg_write(REG_RANGE_LOW, c.range_low);
		reg_write(REG_RANGE_HIGH, c.range_high);
		reg_write(REG_STEP_SIZE, c.step_size);
		reg_write(REG_SCAN_TOTAL, c.scan_total);
	endtask

	task automatic add_word(input logic act, input logic [15:0] pos);
		stim_row_t row;
		row.kind   = ROW_WORD;
		row.act    = act;
		row.pos    = pos;
		row.regs   = '0;
		row.pinned = '0;
		plan.push_back(row);
	endtask

	task automatic add_pinned(input logic act, input logic [15:0] pos, input logic pulse,
			input logic level, input logic [31:0] count, input logic [16:0] scans,
			input logic busy, input logic done);
		stim_row_t row;
		row.kind            = ROW_PINNED;
		row.act             = act;
		row.pos             = pos;
		row.regs            = '0;
		row.pinned.pulse    = pulse;
		row.pinned.level    = level;
		row.pinned.count    = count;
		row.pinned.scans    = scans;
		row.pinned.busy     = busy;
		row.pinned.run_done = done;
		plan.push_back(row);
	endtask

	task automatic add_regs(input logic [15:0] lo, input logic [15:0] hi,
			input logic [15:0] stp, input logic [15:0] total);
		stim_row_t row;
		row.kind            = ROW_REGS;
		row.act             = 1'b0;
		row.pos             = '0;
		row.regs.range_low  = lo;
		row.regs.range_high = hi;
		row.regs.step_size  = stp;
		row.regs.scan_total = total;
		row.pinned          = '0;
		plan.push_back(row);
	endtask

	// Result checker: every word taken on the result side is matched against
	// the oldest outstanding expectation.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result word with nothing outstanding: %h", m_tdata);
			end else begin
				want = due_results.pop_front();
				check_field("trigger_pulse", want.pulse, m_tdata[0]);
				check_field("trigger_level", want.level, m_tdata[1]);
				check_field("trigger_count", want.count, m_tdata[33:2]);
				check_field("scans_done", want.scans, m_tdata[50:34]);
				check_field("busy_res", want.busy, m_tdata[51]);
				check_field("tdata padding", '0, m_tdata[55:52]);
				check_field("run_done", want.run_done, m_tlast);
			end
		end
	end

	// Result-side stalls: the mode is drawn at random, over and over, from always
	// ready, a fixed rotating pattern, and random stalls.
	initial begin
		int mode;
		int tick;
		int pat_idx;
		m_tready = 1'b0;
		mode     = 0;
		tick     = 0;
		pat_idx  = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (tick % 150 == 0)
				mode = $urandom_range(0, 2);
			tick++;
			case (mode)
				0: m_tready = 1'b1;
				1: begin
					m_tready = STALL_PAT[pat_idx];
					pat_idx  = (pat_idx + 1) % 11;
				end
				default: m_tready = ($urandom_range(0, 9) > 3);
			endcase
		end
	end

	// Watchdog: far beyond the slowest legal run under the heaviest stalls.
	initial begin
		#2_400_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int   ph;
		int   sent;
		int   roll;
		int   t;
		int   lo;
		int   hi;
		int   stp;
		int   thr;
		int   room;
		int   span;
		logic act;
		logic finishing;
		cfg_t c;

		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		shadow_cfg  = '0;
		sweep_phase = PH_IDLE;
		sweep_thr   = '0;
		sweep_scans = '0;
		sweep_fires = '0;
		sweep_level = 1'b0;
		mismatches  = 0;
		burst_left  = $urandom_range(1, 24);
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. Straight after reset a sample does nothing and a
		// start with no scans asked for finishes on the spot.
		add_pinned(1'b0, 16'h0000, 1'b0, 1'b0, 32'd0, 17'd0, 1'b0, 1'b0);
		add_pinned(1'b1, 16'h7FFF, 1'b0, 1'b0, 32'd0, 17'd0, 1'b0, 1'b1);
		// A full up and down pair over 100..300 in steps of 100, touching the
		// position extremes on the way.
		add_regs(16'd100, 16'd300, 16'd100, 16'd2);
		add_pinned(1'b1, 16'h8000, 1'b0, 1'b0, 32'd0, 17'd0, 1'b1, 1'b0);
		add_word(1'b0, 16'h8000);
		add_word(1'b0, 16'd150);
		add_word(1'b0, 16'h7FFF);
		add_word(1'b0, 16'd400);
		add_word(1'b0, 16'd500);
		add_word(1'b0, 16'd250);
		add_word(1'b0, 16'h8000);
		add_word(1'b0, 16'd100);
		add_word(1'b0, 16'hFF9C);
		add_pinned(1'b0, 16'd0, 1'b0, 1'b0, 32'd6, 17'd2, 1'b0, 1'b0);
		// Zero step with the low bound above the high bound and an odd total;
		// a restart mid-run, then a position that already clears the up wait.
		add_regs(16'd500, 16'd200, 16'd0, 16'd1);
		add_word(1'b1, 16'd0);
		add_word(1'b0, 16'd100);
		add_word(1'b1, 16'hFFFF);
		add_word(1'b0, 16'd200);
		add_pinned(1'b0, 16'd150, 1'b1, 1'b1, 32'd1, 17'd2, 1'b0, 1'b1);
		add_word(1'b0, 16'hFFFF);

		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_REGS: begin
					drain();
					program_regs(plan[i].regs);
				end
				ROW_PINNED: send_word(plan[i].act, plan[i].pos, 1'b1, plan[i].pinned);
				default:    send_word(plan[i].act, plan[i].pos, 1'b0, '0);
			endcase
		end

		// Random part: eight settings, each with about eighty words. Most
		// words follow the scan so that runs get all the way round; the rest
		// are near misses, random samples and restarts. Once the budget is
		// spent the scan is pushed to its end so the next settings can go in.
		for (ph = 0; ph < 8; ph++) begin
			drain();
			case ($urandom_range(0, 9))
				0:          stp = 0;
				1, 2, 3, 4: stp = $urandom_range(1, 20);
				5, 6, 7:    stp = $urandom_range(21, 500);
				default:    stp = $urandom_range(501, 2700);
			endcase
			// Keep the upper clear limit inside the position range, and the lower one
			// too unless low is above high; keep the number of triggers per scan small.
			room = 32767 - 2 * stp;
			if (stp == 0 || $urandom_range(0, 4) == 0) begin
				hi = $urandom_range(0, room);
				lo = $urandom_range(hi + 1, 65535);
			end else begin
				span = $urandom_range(0, (room < 12 * stp) ? room : 12 * stp);
				lo   = $urandom_range(0, room - span);
				hi   = lo + span;
			end
			c.range_low  = 16'(lo);
			c.range_high = 16'(hi);
			c.step_size  = 16'(stp);
			c.scan_total = 16'($urandom_range(0, 5));
			program_regs(c);

			sent = 0;
			while (sent < 80 || sweep_phase != PH_IDLE) begin
				finishing = (sent >= 80);
				roll      = $urandom_range(0, 99);
				act       = 1'b0;
				thr       = int'(sweep_thr);
				case (sweep_phase)
					PH_UP:        t = thr + int'($urandom_range(0, 2 * stp + 2));
					PH_WAIT_UP:   t = hi + 2 * stp + int'($urandom_range(0, 3));
					PH_DOWN:      t = thr - int'($urandom_range(0, 2 * stp + 2));
					PH_WAIT_DOWN: t = lo - 2 * stp - int'($urandom_range(0, 3));
					default:      t = int'($urandom_range(0, 65535)) - 32768;
				endcase
				if (!finishing) begin
					if (sweep_phase == PH_IDLE ? roll < 60 : roll < 4)
						act = 1'b1;
					else if (roll < 24)
						t = int'($urandom_range(0, 65535)) - 32768;
					else if (roll < 40)
						t = t + int'($urandom_range(0, 16)) - 8;
				end
				if (t > 32767)
					t = 32767;
				if (t < -32768)
					t = -32768;
				send_word(act, 16'(t), 1'b0, '0);
				sent++;
			end
		end

		// A longer run with low just above high and no step, so each pair of
		// words completes an up and a down scan; the odd total makes the run
		// end one scan over.
		drain();
		c.range_low  = 16'd1;
		c.range_high = 16'd0;
		c.step_size  = 16'd0;
		c.scan_total = 16'd41;
		program_regs(c);
		send_word(1'b1, 16'(int'($urandom_range(0, 65535))), 1'b0, '0);
		while (sweep_phase != PH_IDLE) begin
			if (sweep_phase == PH_UP)
				t = int'($urandom_range(1, 32767));
			else
				t = -int'($urandom_range(0, 32768));
			send_word(1'b0, 16'(t), 1'b0, '0);
		end

		// All registers at their top value: the threshold is out of reach, so
		// the run never fires and is simply left going.
		drain();
		c.range_low  = 16'hFFFF;
		c.range_high = 16'hFFFF;
		c.step_size  = 16'hFFFF;
		c.scan_total = 16'hFFFF;
		program_regs(c);
		send_word(1'b1, 16'h0000, 1'b0, '0);
		repeat (40) begin
			act = ($urandom_range(0, 7) == 0);
			send_word(act, 16'($urandom_range(0, 65535)), 1'b0, '0);
		end

		drain();
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
